FILE: sv/fvs_pkg.sv
package fvs_pkg;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ENV_SET,
    S_E_XX,
    S_E_XXX,
    S_E_KX,
    S_E_MM,
    S_E_MMM,
    S_E_DIV,
    S_PH_MOD,
    S_SIN_IDX,
    S_SIN_POS,
    S_SIN_Q2,
    S_SIN_T1,
    S_SIN_T2,
    S_SIN_S,
    S_FM1,
    S_FM2,
    S_PH_CAR,
    S_OUT1,
    S_OUT2,
    S_OUT3,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    REG_CAR_STEP  = 3'd0,
    REG_MOD_STEP  = 3'd1,
    REG_MOD_INDEX = 3'd2,
    REG_VOLUME    = 3'd3,
    REG_CAR_TIMES = 3'd4,
    REG_MOD_TIMES = 3'd5,
    REG_SUSTAIN   = 3'd6
  } reg_idx_t;

  localparam logic [15:0] FULL_Q15   = 16'd32768;
  localparam logic [14:0] MAX_SAMPLE = 15'd32767;
  localparam logic [16:0] SIN_A1     = 17'd102944;
  localparam logic [16:0] SIN_B1     = 17'd42334;
  localparam logic [16:0] SIN_C1     = 17'd4926;

  localparam int DIV_QW = 18;
  localparam int DIV_CW = 5;
  localparam logic [DIV_CW-1:0] ENV_QBITS = 5'd16;
  localparam logic [DIV_CW-1:0] SIN_QBITS = 5'd18;

endpackage

FILE: sv/fm_voice_adsr_sample_gen_top.sv
// Two-operator FM voice with cubic ADSR envelopes.
// Input channel (in_valid/in_ready): in_func = 0 is a tick transaction that
// yields one clamped signed 16-bit sample on the output channel and then
// advances the sample counter; in_func = 1 loads the counter from
// in_new_count and yields nothing.
// Output channel (out_valid/out_ready): one sample per tick, held in an
// output register; in_ready returns while that sample waits to be taken.
// Config port: cfg_we writes cfg_wdata to register cfg_index at once;
// write only while the block is idle.
// Tick duration is data dependent. All multiplies and divides
// run through one bit-serial shift-add multiplier (it steps through the
// multiplier bits up to the highest set bit) and one restoring divider
// (one quotient bit per cycle).
// One transaction is processed at a time.
// Reset: counter and registers clear, volume to 1.0, no sample pending.
// A stalled receiver holds the finished sample; the next tick completes its
// math and then waits until the output register frees up.
module fm_voice_adsr_sample_gen_top #(
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic        in_key_down,
  input  logic [31:0] in_release_sample,
  input  logic [31:0] in_new_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_sample,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);

  logic [31:0] car_step_r, mod_step_r, sus_r;
  logic [15:0] mod_index_r, volume_r;
  logic [47:0] car_times_r, mod_times_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      car_step_r  <= '0;
      mod_step_r  <= '0;
      mod_index_r <= '0;
      volume_r    <= fvs_pkg::FULL_Q15;
      car_times_r <= '0;
      mod_times_r <= '0;
      sus_r       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        fvs_pkg::REG_CAR_STEP:  car_step_r  <= cfg_wdata[31:0];
        fvs_pkg::REG_MOD_STEP:  mod_step_r  <= cfg_wdata[31:0];
        fvs_pkg::REG_MOD_INDEX: mod_index_r <= cfg_wdata[15:0];
        fvs_pkg::REG_VOLUME:    volume_r    <= cfg_wdata[15:0];
        fvs_pkg::REG_CAR_TIMES: car_times_r <= cfg_wdata;
        fvs_pkg::REG_MOD_TIMES: mod_times_r <= cfg_wdata;
        fvs_pkg::REG_SUSTAIN:   sus_r       <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  fvs_pkg::state_t state_r, state_nxt;
  logic        pend_r, pend_nxt;
  logic        env_sel_r, env_sel_nxt, sin_sel_r, sin_sel_nxt;
  logic        down_r, down_nxt;
  logic [31:0] rel_r, rel_nxt;
  logic [31:0] count_r, count_nxt;
  logic [15:0] base_r, base_nxt, k_r, k_nxt, x_r, x_nxt, m_r, m_nxt;
  logic [63:0] tmp_r, tmp_nxt, num_r, num_nxt;
  logic [15:0] c_env_r, c_env_nxt, m_env_r, m_env_nxt;
  logic [31:0] phase_r, phase_nxt;
  logic [16:0] q_r, q_nxt, q2_r, q2_nxt, t1_r, t1_nxt, t2_r, t2_nxt;
  logic        quad_r, quad_nxt;
  logic [14:0] msin_r, msin_nxt, csin_r, csin_nxt;
  logic        mneg_r, mneg_nxt, cneg_r, cneg_nxt;
  logic [15:0] res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_sample_r, out_sample_nxt;

  logic        mul_start, mul_done, div_start, div_done;
  logic [63:0] mul_a, mul_prod, div_num, div_dsh;
  logic [31:0] mul_b;
  logic [fvs_pkg::DIV_CW-1:0] div_n;
  logic [fvs_pkg::DIV_QW-1:0] div_quo;

  fvs_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_prod)
  );

  fvs_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .dsh(div_dsh),
    .nbits(div_n), .done(div_done), .quo(div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fvs_pkg::S_IDLE;
      pend_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    env_sel_r    <= env_sel_nxt;
    sin_sel_r    <= sin_sel_nxt;
    down_r       <= down_nxt;
    rel_r        <= rel_nxt;
    base_r       <= base_nxt;
    k_r          <= k_nxt;
    x_r          <= x_nxt;
    m_r          <= m_nxt;
    tmp_r        <= tmp_nxt;
    num_r        <= num_nxt;
    c_env_r      <= c_env_nxt;
    m_env_r      <= m_env_nxt;
    phase_r      <= phase_nxt;
    q_r          <= q_nxt;
    q2_r         <= q2_nxt;
    t1_r         <= t1_nxt;
    t2_r         <= t2_nxt;
    quad_r       <= quad_nxt;
    msin_r       <= msin_nxt;
    csin_r       <= csin_nxt;
    mneg_r       <= mneg_nxt;
    cneg_r       <= cneg_nxt;
    res_r        <= res_nxt;
    out_sample_r <= out_sample_nxt;
  end

  // envelope segment select and multiplier product taps
  logic [47:0] times;
  logic [15:0] sus_raw, sus_s, ta, td, tr;
  logic [32:0] ad_end, rel_end;
  logic [16:0] s_sum;
  logic [31:0] fm_off;
  logic [31:0] offset;
  logic [33:0] out_p;

  always_comb begin
    times   = env_sel_r ? mod_times_r : car_times_r;
    sus_raw = env_sel_r ? sus_r[31:16] : sus_r[15:0];
    sus_s   = (sus_raw > fvs_pkg::FULL_Q15) ? fvs_pkg::FULL_Q15 : sus_raw;
    ta      = times[15:0];
    td      = times[31:16];
    tr      = times[47:32];
    ad_end  = 33'(ta) + 33'(td);
    rel_end = 33'(rel_r) + 33'(tr);
    s_sum   = 17'(mul_prod[63:16]) + 17'd1;
    fm_off  = mul_prod[41:10];
    offset  = mneg_r ? (32'd0 - fm_off) : fm_off;
    out_p   = 34'(mul_prod >> 30);
  end

  always_comb begin
    state_nxt      = state_r;
    pend_nxt       = pend_r;
    env_sel_nxt    = env_sel_r;
    sin_sel_nxt    = sin_sel_r;
    down_nxt       = down_r;
    rel_nxt        = rel_r;
    count_nxt      = count_r;
    base_nxt       = base_r;
    k_nxt          = k_r;
    x_nxt          = x_r;
    m_nxt          = m_r;
    tmp_nxt        = tmp_r;
    num_nxt        = num_r;
    c_env_nxt      = c_env_r;
    m_env_nxt      = m_env_r;
    phase_nxt      = phase_r;
    q_nxt          = q_r;
    q2_nxt         = q2_r;
    t1_nxt         = t1_r;
    t2_nxt         = t2_r;
    quad_nxt       = quad_r;
    msin_nxt       = msin_r;
    csin_nxt       = csin_r;
    mneg_nxt       = mneg_r;
    cneg_nxt       = cneg_r;
    res_nxt        = res_r;
    out_sample_nxt = out_sample_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    in_ready       = (state_r == fvs_pkg::S_IDLE);
    mul_start      = 1'b0;
    mul_a          = '0;
    mul_b          = '0;
    div_start      = 1'b0;
    div_num        = num_r;
    div_dsh        = '0;
    div_n          = '0;

    case (state_r)
      fvs_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_func) begin
            count_nxt = in_new_count;
          end else begin
            down_nxt    = in_key_down;
            rel_nxt     = in_release_sample;
            env_sel_nxt = 1'b0;
            state_nxt   = fvs_pkg::S_ENV_SET;
          end
        end
      end
      fvs_pkg::S_ENV_SET: begin
        base_nxt  = '0;
        state_nxt = fvs_pkg::S_E_XX;
        if (down_r) begin
          if (33'(count_r) <= 33'(ta)) begin
            if (ta == '0) begin
              res_nxt   = fvs_pkg::FULL_Q15;
              state_nxt = fvs_pkg::S_E_DIV;
            end else begin
              k_nxt = fvs_pkg::FULL_Q15;
              x_nxt = count_r[15:0];
              m_nxt = ta;
            end
          end else if (33'(count_r) <= ad_end) begin
            base_nxt = sus_s;
            k_nxt    = fvs_pkg::FULL_Q15 - sus_s;
            x_nxt    = 16'(ad_end - 33'(count_r));
            m_nxt    = td;
          end else begin
            res_nxt   = sus_s;
            state_nxt = fvs_pkg::S_E_DIV;
          end
        end else if (count_r >= rel_r && 33'(count_r) <= rel_end) begin
          if (tr == '0) begin
            res_nxt   = sus_s;
            state_nxt = fvs_pkg::S_E_DIV;
          end else begin
            k_nxt = sus_s;
            x_nxt = 16'(rel_end - 33'(count_r));
            m_nxt = tr;
          end
        end else begin
          res_nxt   = '0;
          state_nxt = fvs_pkg::S_E_DIV;
        end
        // constant levels skip the math: pend set marks the result ready
        pend_nxt = (state_nxt == fvs_pkg::S_E_DIV);
      end
      fvs_pkg::S_E_XX: begin
        mul_a = 64'(x_r);
        mul_b = 32'(x_r);
        if (!pend_r) begin
          mul_start = 1'b1;
          pend_nxt  = 1'b1;
        end else if (mul_done) begin
          tmp_nxt   = mul_prod;
          pend_nxt  = 1'b0;
          state_nxt = fvs_pkg::S_E_XXX;
        end
      end
      fvs_pkg::S_E_XXX: begin
        mul_a = tmp_r;
        mul_b = 32'(x_r);
        if (!pend_r) begin
          mul_start = 1'b1;
          pend_nxt  = 1'b1;
        end else if (mul_done) begin
          tmp_nxt   = mul_prod;
          pend_nxt  = 1'b0;
          state_nxt = fvs_pkg::S_E_KX;
        end
      end
      fvs_pkg::S_E_KX: begin
        mul_a = tmp_r;
        mul_b = 32'(k_r);
        if (!pend_r) begin
          mul_start = 1'b1;
          pend_nxt  = 1'b1;
        end else if (mul_done) begin
          num_nxt   = mul_prod;
          pend_nxt  = 1'b0;
          state_nxt = fvs_pkg::S_E_MM;
        end
      end
      fvs_pkg::S_E_MM: begin
        mul_a = 64'(m_r);
        mul_b = 32'(m_r);
        if (!pend_r) begin
          mul_start = 1'b1;
          pend_nxt  = 1'b1;
        end else if (mul_done) begin
          tmp_nxt   = mul_prod;
          pend_nxt  = 1'b0;
          state_nxt = fvs_pkg::S_E_MMM;
        end
      end
      fvs_pkg::S_E_MMM: begin
        mul_a = tmp_r;
        mul_b = 32'(m_r);
        if (!pend_r) begin
          mul_start = 1'b1;
          pend_nxt  = 1'b1;
        end else if (mul_done) begin
          tmp_nxt   = mul_prod;
          pend_nxt  = 1'b0;
          state_nxt = fvs_pkg::S_E_DIV;
          div_start = 1'b1;
          div_dsh   = mul_prod << 15;
          div_n     = fvs_pkg::ENV_QBITS;
        end
      end
      fvs_pkg::S_E_DIV: begin
        // pend high: res_r already holds a constant level
        if (pend_r || div_done) begin
          if (pend_r) begin
            if (env_sel_r) m_env_nxt = res_r;
            else           c_env_nxt = res_r;
          end else begin
            if (env_sel_r) m_env_nxt = base_r + div_quo[15:0];
            else           c_env_nxt = base_r + div_quo[15:0];
          end
          pend_nxt = 1'b0;
          if (env_sel_r) begin
            state_nxt = fvs_pkg::S_PH_MOD;
          end else begin
            env_sel_nxt = 1'b1;
            state_nxt   = fvs_pkg::S_ENV_SET;
          end
        end
      end
      fvs_pkg::S_PH_MOD: begin
        mul_a = 64'(mod_step_r);
        mul_b = count_r;
        if (!pend_r) begin
          mul_start = 1'b1;
          pend_nxt  = 1'b1;
        end else if (mul_done) begin
          phase_nxt   = mul_prod[31:0];
          sin_sel_nxt = 1'b0;
          pend_nxt    = 1'b0;
          state_nxt   = fvs_pkg::S_SIN_IDX;
        end
      end
      fvs_pkg::S_SIN_IDX: begin
        mul_a = 64'(phase_r);
        mul_b = 32'(SINE_TABLE_DEPTH);
        if (!pend_r) begin
          mul_start = 1'b1;
          pend_nxt  = 1'b1;
        end else if (mul_done) begin
          pend_nxt  = 1'b0;
          state_nxt = fvs_pkg::S_SIN_POS;
          div_start = 1'b1;
          div_num   = 64'(mul_prod[63:32]) << 18;
          div_dsh   = 64'(SINE_TABLE_DEPTH) << 17;
          div_n     = fvs_pkg::SIN_QBITS;
        end
      end
      fvs_pkg::S_SIN_POS: begin
        if (div_done) begin
          quad_nxt  = div_quo[17];
          q_nxt     = div_quo[16] ? (17'h10000 - 17'(div_quo[15:0]))
                                  : 17'(div_quo[15:0]);
          state_nxt = fvs_pkg::S_SIN_Q2;
        end
      end
      fvs_pkg::S_SIN_Q2: begin
        mul_a = 64'(q_r);
        mul_b = 32'(q_r);
        if (!pend_r) begin
          mul_start = 1'b1;
          pend_nxt  = 1'b1;
        end else if (mul_done) begin
          q2_nxt    = 17'(mul_prod[63:16]);
          pend_nxt  = 1'b0;
          state_nxt = fvs_pkg::S_SIN_T1;
        end
      end
      fvs_pkg::S_SIN_T1: begin
        mul_a = 64'(fvs_pkg::SIN_C1);
        mul_b = 32'(q2_r);
        if (!pend_r) begin
          mul_start = 1'b1;
          pend_nxt  = 1'b1;
        end else if (mul_done) begin
          t1_nxt    = fvs_pkg::SIN_B1 - 17'(mul_prod[63:16]);
          pend_nxt  = 1'b0;
          state_nxt = fvs_pkg::S_SIN_T2;
        end
      end
      fvs_pkg::S_SIN_T2: begin
        mul_a = 64'(t1_r);
        mul_b = 32'(q2_r);
        if (!pend_r) begin
          mul_start = 1'b1;
          pend_nxt  = 1'b1;
        end else if (mul_done) begin
          t2_nxt    = fvs_pkg::SIN_A1 - 17'(mul_prod[63:16]);
          pend_nxt  = 1'b0;
          state_nxt = fvs_pkg::S_SIN_S;
        end
      end
      fvs_pkg::S_SIN_S: begin
        mul_a = 64'(t2_r);
        mul_b = 32'(q_r);
        if (!pend_r) begin
          mul_start = 1'b1;
          pend_nxt  = 1'b1;
        end else if (mul_done) begin
          pend_nxt = 1'b0;
          if (sin_sel_r) begin
            csin_nxt  = (s_sum[16:1] > 16'(fvs_pkg::MAX_SAMPLE)) ? fvs_pkg::MAX_SAMPLE
                                                                 : s_sum[15:1];
            cneg_nxt  = quad_r;
            state_nxt = fvs_pkg::S_OUT1;
          end else begin
            msin_nxt  = (s_sum[16:1] > 16'(fvs_pkg::MAX_SAMPLE)) ? fvs_pkg::MAX_SAMPLE
                                                                 : s_sum[15:1];
            mneg_nxt  = quad_r;
            state_nxt = fvs_pkg::S_FM1;
          end
        end
      end
      fvs_pkg::S_FM1: begin
        mul_a = 64'(m_env_r);
        mul_b = 32'(mod_index_r);
        if (!pend_r) begin
          mul_start = 1'b1;
          pend_nxt  = 1'b1;
        end else if (mul_done) begin
          tmp_nxt   = mul_prod;
          pend_nxt  = 1'b0;
          state_nxt = fvs_pkg::S_FM2;
        end
      end
      fvs_pkg::S_FM2: begin
        mul_a = tmp_r;
        mul_b = 32'(msin_r);
        if (!pend_r) begin
          mul_start = 1'b1;
          pend_nxt  = 1'b1;
        end else if (mul_done) begin
          phase_nxt = offset;
          pend_nxt  = 1'b0;
          state_nxt = fvs_pkg::S_PH_CAR;
        end
      end
      fvs_pkg::S_PH_CAR: begin
        mul_a = 64'(car_step_r);
        mul_b = count_r;
        if (!pend_r) begin
          mul_start = 1'b1;
          pend_nxt  = 1'b1;
        end else if (mul_done) begin
          phase_nxt   = mul_prod[31:0] + phase_r;
          sin_sel_nxt = 1'b1;
          pend_nxt    = 1'b0;
          state_nxt   = fvs_pkg::S_SIN_IDX;
        end
      end
      fvs_pkg::S_OUT1: begin
        mul_a = 64'(c_env_r);
        mul_b = 32'(csin_r);
        if (!pend_r) begin
          mul_start = 1'b1;
          pend_nxt  = 1'b1;
        end else if (mul_done) begin
          tmp_nxt   = mul_prod;
          pend_nxt  = 1'b0;
          state_nxt = fvs_pkg::S_OUT2;
        end
      end
      fvs_pkg::S_OUT2: begin
        mul_a = tmp_r;
        mul_b = 32'(volume_r);
        if (!pend_r) begin
          mul_start = 1'b1;
          pend_nxt  = 1'b1;
        end else if (mul_done) begin
          tmp_nxt   = mul_prod >> 15;
          pend_nxt  = 1'b0;
          state_nxt = fvs_pkg::S_OUT3;
        end
      end
      fvs_pkg::S_OUT3: begin
        mul_a = tmp_r;
        mul_b = 32'(fvs_pkg::MAX_SAMPLE);
        if (!pend_r) begin
          mul_start = 1'b1;
          pend_nxt  = 1'b1;
        end else if (mul_done) begin
          res_nxt = (out_p > 34'(fvs_pkg::MAX_SAMPLE)) ? 16'(fvs_pkg::MAX_SAMPLE)
                                                       : out_p[15:0];
          if (cneg_r) begin
            res_nxt = 16'd0 - res_nxt;
          end
          pend_nxt  = 1'b0;
          state_nxt = fvs_pkg::S_DONE;
        end
      end
      fvs_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = res_r;
          count_nxt      = count_r + 32'd1;
          state_nxt      = fvs_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fvs_pkg::S_IDLE;
        pend_nxt  = 1'b0;
      end
    endcase
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

FILE: sv/fvs_mul.sv
module fvs_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [63:0] prod
);

  logic [63:0] a_r, acc_r;
  logic [31:0] b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r <= '0;
    end else if (start) begin
      b_r <= b;
    end else if (b_r != '0) begin
      b_r <= b_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      acc_r <= '0;
    end else if (b_r != '0) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r << 1;
    end
  end

  assign done = (b_r == '0);
  assign prod = acc_r;

endmodule

FILE: sv/fvs_div.sv
module fvs_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [63:0]                    num,
  input  logic [63:0]                    dsh,
  input  logic [fvs_pkg::DIV_CW-1:0]     nbits,
  output logic                           done,
  output logic [fvs_pkg::DIV_QW-1:0]     quo
);

  logic [63:0]                rem_r, dsh_r;
  logic [fvs_pkg::DIV_QW-1:0] quo_r;
  logic [fvs_pkg::DIV_CW-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= nbits;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= dsh;
      quo_r <= '0;
    end else if (cnt_r != '0) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        quo_r <= {quo_r[fvs_pkg::DIV_QW-2:0], 1'b1};
      end else begin
        quo_r <= {quo_r[fvs_pkg::DIV_QW-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
  end

  assign done = (cnt_r == '0);
  assign quo  = quo_r;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_func;
  logic        in_key_down;
  logic [31:0] in_release_sample;
  logic [31:0] in_new_count;
  logic        out_valid;
  logic        out_ready;
  logic signed [15:0] out_sample;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [47:0] cfg_wdata;

  fm_voice_adsr_sample_gen_top dut (.*);

  localparam int SINE_DEPTH = 1024;
  localparam int UNKNOWN_REG = 7;

  typedef struct {
    bit        func;
    bit        key_down;
    bit [31:0] release_at;
    bit [31:0] new_count;
    bit        known;
    bit [15:0] sample;
  } vector_t;

  bit [31:0] m_car_step;
  bit [31:0] m_mod_step;
  bit [15:0] m_mod_index;
  bit [15:0] m_volume;
  bit [47:0] m_car_times;
  bit [47:0] m_mod_times;
  bit [31:0] m_sustain;
  bit [31:0] m_count;

  bit [15:0] sample_q[$];
  int        errors;
  bit        quiet;
  vector_t   vec_tab[$];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #500ms;
    $display("fm_voice_adsr_sample_gen_top verification failed");
    $finish;
  end

  function automatic int sine_lookup(bit [31:0] phase);
    bit [63:0] idx, pos, q, q2, t1, t2, s;
    bit [1:0]  quad;
    idx = ({32'd0, phase} * SINE_DEPTH) >> 32;
    pos = (idx * 4 * 65536) / SINE_DEPTH;
    quad = pos[17:16];
    q = pos & 64'hFFFF;
    if (quad[0]) q = 65536 - q;
    q2 = (q * q) >> 16;
    t1 = 42334 - ((q2 * 4926) >> 16);
    t2 = 102944 - ((q2 * t1) >> 16);
    s = (q * t2) >> 16;
    s = (s + 1) >> 1;
    if (s > 32767) s = 32767;
    return quad[1] ? -int'(s) : int'(s);
  endfunction

  function automatic bit [63:0] cube(bit [63:0] x);
    return x * x * x;
  endfunction

  function automatic bit [31:0] envelope(bit [47:0] tms, bit [15:0] sus_raw, bit down,
                                         bit [31:0] rel_at);
    bit [63:0] a, d, r, s, t;
    a = tms[15:0];
    d = tms[31:16];
    r = tms[47:32];
    s = sus_raw > 32768 ? 32768 : sus_raw;
    t = m_count;
    if (down) begin
      if (t <= a) begin
        if (a == 0) return 32768;
        return 32'((cube(t) << 15) / cube(a));
      end
      if (t <= a + d) return 32'(s + ((32768 - s) * cube(a + d - t)) / cube(d));
      return 32'(s);
    end
    if (t >= rel_at && t <= {32'd0, rel_at} + r) begin
      if (r == 0) return 32'(s);
      return 32'((s * cube({32'd0, rel_at} + r - t)) / cube(r));
    end
    return 0;
  endfunction

  function automatic bit predict_voice(bit func, bit down, bit [31:0] rel_at, bit [31:0] nc,
                                       output bit [15:0] smp);
    bit [31:0] c_env, m_env, mph, cph, offset;
    int        m_sin, c_sin;
    bit [63:0] mag, p;
    smp = 0;
    if (func) begin
      m_count = nc;
      return 0;
    end
    c_env = envelope(m_car_times, m_sustain[15:0], down, rel_at);
    m_env = envelope(m_mod_times, m_sustain[31:16], down, rel_at);
    mph = m_mod_step * m_count;
    m_sin = sine_lookup(mph);
    mag = 64'(m_env) * m_mod_index * 64'(m_sin < 0 ? -m_sin : m_sin);
    offset = mag[41:10];
    if (m_sin < 0) offset = -offset;
    cph = m_car_step * m_count + offset;
    c_sin = sine_lookup(cph);
    p = 64'(c_env) * 64'(c_sin < 0 ? -c_sin : c_sin);
    p = (p * m_volume) >> 15;
    p = (p * 32767) >> 30;
    if (p > 32767) p = 32767;
    smp = c_sin < 0 ? -p[15:0] : p[15:0];
    m_count = m_count + 1;
    return 1;
  endfunction

  task automatic write_reg(int idx, bit [47:0] val);
    cfg_we <= 1;
    cfg_index <= idx[2:0];
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      fvs_pkg::REG_CAR_STEP:  m_car_step = val[31:0];
      fvs_pkg::REG_MOD_STEP:  m_mod_step = val[31:0];
      fvs_pkg::REG_MOD_INDEX: m_mod_index = val[15:0];
      fvs_pkg::REG_VOLUME:    m_volume = val[15:0];
      fvs_pkg::REG_CAR_TIMES: m_car_times = val;
      fvs_pkg::REG_MOD_TIMES: m_mod_times = val;
      fvs_pkg::REG_SUSTAIN:   m_sustain = val[31:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    while (sample_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (800) @(posedge clk);
  endtask

  task automatic send(bit func, bit down, bit [31:0] rel_at, bit [31:0] nc);
    bit [15:0] smp;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1;
    in_func <= func;
    in_key_down <= down;
    in_release_sample <= rel_at;
    in_new_count <= nc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (predict_voice(func, down, rel_at, nc, smp)) sample_q.push_back(smp);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (sample_q.size() == 0) begin
          $display("%0t unexpected sample: expected none actual %0d", $time, out_sample);
          errors++;
        end else begin
          if (out_sample !== sample_q[0]) begin
            $display("%0t sample mismatch: expected %0d actual %0d", $time,
                     $signed(sample_q[0]), out_sample);
            errors++;
          end
          void'(sample_q.pop_front());
        end
      end
      if (quiet) out_ready <= 1;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic random_phase(int n);
    bit [31:0] base, rel;
    bit        down;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        base = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 3000);
        send(1, $urandom_range(0, 1), $urandom(), base);
      end else begin
        down = $urandom_range(0, 2) != 0;
        rel = $urandom_range(0, 4) == 0 ? $urandom() : m_count - $urandom_range(0, 800);
        send(0, down, rel, $urandom());
      end
    end
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic random_config;
    write_reg(fvs_pkg::REG_CAR_STEP, $urandom());
    write_reg(fvs_pkg::REG_MOD_STEP, $urandom());
    write_reg(fvs_pkg::REG_MOD_INDEX,
              $urandom_range(0, 3) == 0 ? 16'hFFFF : $urandom_range(0, 16'hFFFF));
    write_reg(fvs_pkg::REG_VOLUME, $urandom_range(0, 65535));
    write_reg(fvs_pkg::REG_CAR_TIMES, {16'($urandom_range(0, 600)),
                                       16'($urandom_range(0, 600)),
                                       16'($urandom_range(0, 600))});
    write_reg(fvs_pkg::REG_MOD_TIMES, {16'($urandom_range(0, 600)),
                                       16'($urandom_range(0, 600)),
                                       16'($urandom_range(0, 600))});
    write_reg(fvs_pkg::REG_SUSTAIN, $urandom());
  endtask

  initial begin
    vector_t v;
    errors = 0;
    quiet = 0;
    rst_n = 0;
    in_valid = 0;
    in_func = 0;
    in_key_down = 0;
    in_release_sample = 0;
    in_new_count = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    m_car_step = 0;
    m_mod_step = 0;
    m_mod_index = 0;
    m_volume = 32768;
    m_car_times = 0;
    m_mod_times = 0;
    m_sustain = 0;
    m_count = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // after reset: zero phase, sine 0 -> sample 0
    vec_tab.push_back('{0, 1, 0, 0, 1, 16'd0});
    vec_tab.push_back('{0, 0, 0, 0, 1, 16'd0});
    foreach (vec_tab[i]) begin
      v = vec_tab[i];
      send(v.func, v.key_down, v.release_at, v.new_count);
      if (v.known && sample_q.size() != 0 && sample_q[$] !== v.sample) begin
        $display("%0t table mismatch: expected %0d actual %0d", $time, v.sample, sample_q[$]);
        errors++;
      end
    end
    in_valid <= 0;
    drain();

    write_reg(fvs_pkg::REG_CAR_STEP, 32'h4000_0000);
    write_reg(fvs_pkg::REG_MOD_STEP, 32'hFFFF_FFFF);
    write_reg(fvs_pkg::REG_MOD_INDEX, 16'hFFFF);
    write_reg(fvs_pkg::REG_VOLUME, 16'hFFFF);
    write_reg(fvs_pkg::REG_CAR_TIMES, {16'd0, 16'd5, 16'd0});
    write_reg(fvs_pkg::REG_MOD_TIMES, {16'hFFFF, 16'hFFFF, 16'hFFFF});
    write_reg(fvs_pkg::REG_SUSTAIN, 32'hFFFF_FFFF);
    write_reg(UNKNOWN_REG, 48'hFFFF_FFFF_FFFF);
    vec_tab.delete();
    vec_tab.push_back('{1, 0, 0, 32'hFFFF_FFFE, 0, 0});
    vec_tab.push_back('{0, 1, 0, 0, 0, 0});
    vec_tab.push_back('{0, 1, 0, 0, 0, 0});
    vec_tab.push_back('{0, 1, 0, 0, 0, 0});
    vec_tab.push_back('{1, 1, 32'hFFFF_FFFF, 0, 0, 0});
    vec_tab.push_back('{0, 1, 0, 0, 0, 0});
    vec_tab.push_back('{0, 1, 0, 0, 0, 0});
    vec_tab.push_back('{0, 1, 0, 0, 0, 0});
    vec_tab.push_back('{0, 1, 0, 0, 0, 0});
    vec_tab.push_back('{0, 1, 0, 0, 0, 0});
    vec_tab.push_back('{0, 1, 0, 0, 0, 0});
    vec_tab.push_back('{0, 0, 7, 0, 0, 0});
    vec_tab.push_back('{0, 0, 7, 0, 0, 0});
    vec_tab.push_back('{0, 0, 32'hFFFF_FFFF, 0, 0, 0});
    vec_tab.push_back('{1, 0, 0, 32'd100, 0, 0});
    vec_tab.push_back('{0, 0, 32'd100, 0, 0, 0});
    foreach (vec_tab[i]) begin
      v = vec_tab[i];
      send(v.func, v.key_down, v.release_at, v.new_count);
    end
    in_valid <= 0;
    drain();

    write_reg(fvs_pkg::REG_CAR_TIMES, {16'd0, 16'd0, 16'd0});
    write_reg(fvs_pkg::REG_SUSTAIN, 32'd0);
    write_reg(fvs_pkg::REG_VOLUME, 16'd0);
    write_reg(fvs_pkg::REG_MOD_INDEX, 16'd0);
    send(1, 0, 0, 0);
    send(0, 0, 0, 0);
    send(0, 1, 0, 0);
    in_valid <= 0;
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      random_config();
      if (ph == 7) quiet = 1;
      random_phase(250);
      drain();
    end

    if (errors == 0) $display("fm_voice_adsr_sample_gen_top verification clean");
    else $display("fm_voice_adsr_sample_gen_top verification failed");
    $finish;
  end
endmodule
